@@ design/linear_motion_position_3d_top_macros.svh @@
// Assertion macros shared by the linear motion position RTL.
// Define ASSERT_OFF to compile every assertion out.
`ifndef LINEAR_MOTION_POSITION_3D_TOP_MACROS_SVH
`define LINEAR_MOTION_POSITION_3D_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop at every clock edge outside reset.
`define LMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("linear motion assertion failed");

// Check that post holds in the cycle after pre.
`define LMP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("linear motion assertion failed");

`else

`define LMP_ASSERT(lbl, clk, rst_n, prop)
`define LMP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

@@ design/lmp3d_pkg.sv @@
// Package for the linear motion position block: constants, register codes,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package lmp3d_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COORD_W_DEF = 32;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned AXIS_W      = 2;
  localparam int unsigned CFG_IDX_W   = 3;

  // Direction reduction: components shrink by 4 until within +/- RED_LIMIT
  localparam int unsigned RED_LIMIT   = 100;
  localparam int unsigned DMAG_W      = 7;
  localparam int unsigned SPEED_W     = 12;
  localparam int unsigned FRAC_W      = 12;

  // Velocity division: numerator |d|*speed*4096, divisor floor sqrt of length^2
  localparam int unsigned NUM_W       = DMAG_W + SPEED_W + FRAC_W;
  localparam int unsigned LEN2_W      = 2 * DMAG_W + 1;
  localparam int unsigned ROOT_W      = 8;
  localparam int unsigned ROOT_IDX_W  = 3;
  localparam int unsigned STEP_W      = $clog2(NUM_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_END_X,
    REG_END_Y,
    REG_END_Z,
    REG_START_TIME,
    REG_SPEED
  } cfg_idx_e;

  typedef struct packed {
    logic                  capture_dt;
    logic                  load_diff;
    logic                  red_step;
    logic                  load_sq;
    logic                  sqrt_step;
    logic [ROOT_IDX_W-1:0] sqrt_bit;
    logic                  div_load;
    logic                  div_step;
    logic                  vel_store;
    logic                  vel_zero;
    logic                  mul;
    logic                  add;
    logic                  out_load;
    logic [AXIS_W-1:0]     axis;
  } lmp3d_cmd_t;

  typedef struct packed {
    logic red_done;
    logic len_zero;
  } lmp3d_stat_t;

endpackage

`default_nettype wire

@@ design/linear_motion_position_3d_top.sv @@
// Top level of the linear motion position block: controller plus datapath.
// Depends on lmp3d_pkg, lmp3d_ctrl and lmp3d_dp.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  cfg      | cfg_valid_i/cfg_ready_o| cfg_index_i (3b), cfg_wdata_i (32b)
//  query in | in_valid_i/in_stall_o  | query_time_i (32b signed)
//  position | out_valid_o/out_stall_i| pos_x_o, pos_y_o, pos_z_o (32b signed)
//
// A query with a valid velocity runs: accept, then a multiply and an add per axis
// on the shared 32x32 multiplier, then the output load.
// The first query after reset or a register write adds the velocity setup: the
// difference, the divide-by-4 passes, the squared length, the 8 root bits, then the
// divider for each of the three axes; a zero length skips to a zero velocity.
// Reset clears configuration and velocity; a waiting result holds the next in its load.
`default_nettype none

module linear_motion_position_3d_top
  import lmp3d_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_W_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DATA_W-1:0]    query_time_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DATA_W-1:0]         pos_x_o,
  output logic [DATA_W-1:0]         pos_y_o,
  output logic [DATA_W-1:0]         pos_z_o
);

  lmp3d_cmd_t  cmd;
  lmp3d_stat_t stat;
  logic        cfg_we;

  // Registers accept a write in any cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  lmp3d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lmp3d_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .query_time_i (query_time_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o)
  );

endmodule

`default_nettype wire

@@ design/lmp3d_ctrl.sv @@
// Controller for the linear motion position block: sequences velocity setup
// and per-query evaluation. Uses lmp3d_pkg and the assertion macro header.
`default_nettype none
`include "linear_motion_position_3d_top_macros.svh"

module lmp3d_ctrl
  import lmp3d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic        cfg_we_i,
  input  wire lmp3d_stat_t stat_i,
  output lmp3d_cmd_t       cmd_o
);

  localparam int unsigned ST_W = 4;

  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_SUB    = 4'd1;
  localparam logic [ST_W-1:0] S_RED    = 4'd2;
  localparam logic [ST_W-1:0] S_SQ     = 4'd3;
  localparam logic [ST_W-1:0] S_SQRT   = 4'd4;
  localparam logic [ST_W-1:0] S_DIV_LD = 4'd5;
  localparam logic [ST_W-1:0] S_DIV    = 4'd6;
  localparam logic [ST_W-1:0] S_DIV_ST = 4'd7;
  localparam logic [ST_W-1:0] S_MUL    = 4'd8;
  localparam logic [ST_W-1:0] S_ADD    = 4'd9;
  localparam logic [ST_W-1:0] S_DONE   = 4'd10;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(NUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_TOP  = STEP_W'(ROOT_W - 1);

  logic [ST_W-1:0]   state_q, state_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              vel_valid_q, vel_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              vel_set;

  // Take a query only when idle
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    step_d       = step_q;
    vel_set      = 1'b0;
    cmd_o        = '0;
    cmd_o.axis   = axis_q;
    cmd_o.sqrt_bit = step_q[ROOT_IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture_dt = 1'b1;
          axis_d           = '0;
          state_d          = vel_valid_q ? S_MUL : S_SUB;
        end
      end
      S_SUB: begin
        cmd_o.load_diff = 1'b1;
        state_d         = S_RED;
      end
      S_RED: begin
        if (stat_i.red_done) begin
          state_d = S_SQ;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      S_SQ: begin
        cmd_o.load_sq = 1'b1;
        step_d        = SQRT_TOP;
        state_d       = S_SQRT;
      end
      S_SQRT: begin
        if (stat_i.len_zero) begin
          cmd_o.vel_zero = 1'b1;
          vel_set        = 1'b1;
          axis_d         = '0;
          state_d        = S_MUL;
        end else begin
          cmd_o.sqrt_step = 1'b1;
          if (step_q == '0) begin
            axis_d  = '0;
            state_d = S_DIV_LD;
          end else begin
            step_d = step_q - 1'b1;
          end
        end
      end
      S_DIV_LD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == DIV_LAST) begin
          state_d = S_DIV_ST;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DIV_ST: begin
        cmd_o.vel_store = 1'b1;
        if (axis_q == AXIS_LAST) begin
          vel_set = 1'b1;
          axis_d  = '0;
          state_d = S_MUL;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_DIV_LD;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        if (axis_q == AXIS_LAST) begin
          state_d = S_DONE;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Drop the velocity on any register write; the write wins over a finishing setup
  always_comb begin
    vel_valid_d = vel_valid_q;
    if (cfg_we_i) begin
      vel_valid_d = 1'b0;
    end else if (vel_set) begin
      vel_valid_d = 1'b1;
    end
  end

  // Hold the result until the output side takes the transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      step_q      <= '0;
      vel_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      step_q      <= step_d;
      vel_valid_q <= vel_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LMP_ASSERT(a_mul_needs_vel, clk_i, rst_ni, (state_q == S_MUL) |-> vel_valid_q)
  `LMP_ASSERT_NEXT(a_cfg_clears_vel, clk_i, rst_ni, cfg_we_i, !vel_valid_q)
  `LMP_ASSERT(a_no_out_overwrite, clk_i, rst_ni, cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
  `LMP_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o, (state_q == S_SUB) || (state_q == S_MUL))

endmodule

`default_nettype wire

@@ design/lmp3d_dp.sv @@
// Datapath for the linear motion position block: config registers, direction
// reduction, square root, velocity divider, multiply-shift-add. Uses lmp3d_pkg.
`default_nettype none

module lmp3d_dp
  import lmp3d_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_W_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_wdata_i,
  input  wire logic [DATA_W-1:0]    query_time_i,
  input  wire lmp3d_cmd_t           cmd_i,
  output lmp3d_stat_t               stat_o,
  output logic [DATA_W-1:0]         pos_x_o,
  output logic [DATA_W-1:0]         pos_y_o,
  output logic [DATA_W-1:0]         pos_z_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam logic signed [CW-1:0] RED_HI = CW'(RED_LIMIT);
  localparam logic signed [CW-1:0] RED_LO = -RED_HI;
  localparam logic [CW-1:0]        ROUND3 = CW'(3);

  // Configuration registers
  logic [CW-1:0]      start_q [NUM_AXES];
  logic [CW-1:0]      end_q   [NUM_AXES];
  logic [DATA_W-1:0]  t0_q;
  logic [SPEED_W-1:0] speed_q;

  // Setup state
  logic signed [CW-1:0] d_q  [NUM_AXES];
  logic signed [CW-1:0] d_red[NUM_AXES];
  logic [DMAG_W-1:0]    mag  [NUM_AXES];
  logic [2*DMAG_W-1:0]  sq   [NUM_AXES];
  logic [NUM_AXES-1:0]  in_rng;
  logic [LEN2_W-1:0]    len2_q;
  logic [ROOT_W-1:0]    root_q;
  logic [ROOT_W-1:0]    trial;
  logic [2*ROOT_W-1:0]  trial_sq;
  logic [NUM_W-1:0]     num_q;
  logic [ROOT_W-1:0]    rem_q;
  logic [ROOT_W:0]      shifted;
  logic                 q_bit;
  logic                 neg_q;
  logic [DMAG_W+SPEED_W-1:0] mag_spd;
  logic [DATA_W-1:0]    quot;

  // Evaluation state
  logic [DATA_W-1:0]        vel_q [NUM_AXES];
  logic [DATA_W-1:0]        dt_q;
  logic [DATA_W-1:0]        prod_q;
  logic signed [DATA_W-1:0] moved;
  logic signed [CW-1:0]     wpos_q[NUM_AXES];
  logic [CW-1:0]            pos_sum;
  logic [DATA_W-1:0]        pos_x_q, pos_y_q, pos_z_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        start_q[a] <= '0;
        end_q[a]   <= '0;
      end
      t0_q    <= '0;
      speed_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_START_X:    start_q[0] <= cfg_wdata_i[CW-1:0];
        REG_START_Y:    start_q[1] <= cfg_wdata_i[CW-1:0];
        REG_START_Z:    start_q[2] <= cfg_wdata_i[CW-1:0];
        REG_END_X:      end_q[0]   <= cfg_wdata_i[CW-1:0];
        REG_END_Y:      end_q[1]   <= cfg_wdata_i[CW-1:0];
        REG_END_Z:      end_q[2]   <= cfg_wdata_i[CW-1:0];
        REG_START_TIME: t0_q       <= cfg_wdata_i;
        REG_SPEED:      speed_q    <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Quarter each component toward zero, check range, take magnitudes
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (d_q[a][CW-1]) begin
        d_red[a] = signed'(d_q[a] + ROUND3) >>> 2;
      end else begin
        d_red[a] = d_q[a] >>> 2;
      end
      in_rng[a] = !((d_q[a] > RED_HI) || (d_q[a] < RED_LO));
      if (d_q[a][CW-1]) begin
        mag[a] = DMAG_W'(-d_q[a]);
      end else begin
        mag[a] = d_q[a][DMAG_W-1:0];
      end
      sq[a] = mag[a] * mag[a];
    end
  end

  assign stat_o.red_done = &in_rng;
  assign stat_o.len_zero = (len2_q == '0);

  // Square root trial bit and one restoring division step
  always_comb begin
    trial    = root_q | (ROOT_W'(1) << cmd_i.sqrt_bit);
    trial_sq = trial * trial;
    shifted  = {rem_q, num_q[NUM_W-1]};
    q_bit    = (shifted >= {1'b0, root_q});
    mag_spd  = mag[cmd_i.axis] * speed_q;
    quot     = DATA_W'(num_q);
  end

  // Setup registers: difference, reduction, length, root, divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_diff) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        d_q[a] <= signed'(end_q[a] - start_q[a]);
      end
    end else if (cmd_i.red_step) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        d_q[a] <= d_red[a];
      end
    end
    if (cmd_i.load_sq) begin
      len2_q <= {1'b0, sq[0]} + {1'b0, sq[1]} + {1'b0, sq[2]};
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      if (trial_sq <= {1'b0, len2_q}) begin
        root_q <= trial;
      end
    end
    if (cmd_i.div_load) begin
      num_q <= {mag_spd, FRAC_W'(0)};
      rem_q <= '0;
      neg_q <= d_q[cmd_i.axis][CW-1];
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], q_bit};
      rem_q <= q_bit ? ROOT_W'(shifted - {1'b0, root_q}) : shifted[ROOT_W-1:0];
    end
  end

  // Velocity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        vel_q[a] <= '0;
      end
    end else if (cmd_i.vel_zero) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        vel_q[a] <= '0;
      end
    end else if (cmd_i.vel_store) begin
      vel_q[cmd_i.axis] <= neg_q ? -quot : quot;
    end
  end

  // Shift the product and add the start point, wrapping at coordinate width
  assign moved   = $signed(prod_q) >>> FRAC_W;
  assign pos_sum = moved[CW-1:0] + start_q[cmd_i.axis];

  // Per-query datapath: time offset, product, position, output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_dt) begin
      dt_q <= query_time_i - t0_q;
    end
    if (cmd_i.mul) begin
      prod_q <= vel_q[cmd_i.axis] * dt_q;
    end
    if (cmd_i.add) begin
      wpos_q[cmd_i.axis] <= signed'(pos_sum);
    end
    if (cmd_i.out_load) begin
      pos_x_q <= DATA_W'(wpos_q[0]);
      pos_y_q <= DATA_W'(wpos_q[1]);
      pos_z_q <= DATA_W'(wpos_q[2]);
    end
  end

  assign pos_x_o = pos_x_q;
  assign pos_y_o = pos_y_q;
  assign pos_z_o = pos_z_q;

endmodule

`default_nettype wire
